>>> src/quaternion_to_euler_zyx_macros.svh
// Assertion macros for the quaternion to Euler angle converter.
// Included by the top level; expects a clock named clk and a reset named rst.
`ifndef QUATERNION_TO_EULER_ZYX_MACROS_SVH
`define QUATERNION_TO_EULER_ZYX_MACROS_SVH

// Clocked property that is switched off while reset is high.
`define Q2E_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication built on the macro above.
`define Q2E_IMPLY(lbl, cond, expr, msg) \
  `Q2E_ASSERT(lbl, (cond) |-> (expr), msg)

`endif

>>> src/q2e_pkg.sv
// Shared types, widths and constants for the quaternion to Euler angle converter.
// No dependencies.
package q2e_pkg;

  localparam int IN_W      = 16;
  localparam int IN_FRAC   = 14;
  localparam int ANG_FRAC  = 13;
  localparam int VEC_W     = 36;
  localparam int CW        = 34;
  localparam int NORM_TOP  = 29;
  localparam int ROOT_W    = 31;
  localparam int SQ_W      = 2 * ROOT_W;
  localparam int POS_W     = 6;
  localparam int TBL_LEN   = 24;
  localparam int S30_SH    = 30 - 2 * IN_FRAC;
  localparam int RND_SH    = 30 - ANG_FRAC;

  localparam longint ONE_TERM    = 64'sd1 <<< (2 * IN_FRAC);
  localparam longint ONE_Q30     = 64'sd1 <<< 30;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint RND_HALF    = 64'sd1 <<< (RND_SH - 1);
  localparam longint PI_LIM      = (PI_Q30 + RND_HALF) >>> RND_SH;
  localparam longint HALF_LIM    = (HALF_PI_Q30 + RND_HALF) >>> RND_SH;

  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [CW-1:0]    cw_t;

  typedef struct packed {
    logic valid;
    logic lock;
    logic neg;
  } ctl_t;

  typedef struct packed {
    vec_t sr;
    vec_t cr;
    vec_t sy;
    vec_t cy;
    vec_t s30;
  } terms_t;

  // atan(2^-i) in Q30, truncated.
  localparam logic [CW-1:0] ATAN_TBL [TBL_LEN] = '{
    34'h3243F6A8, 34'h1DAC6705, 34'h0FADBAFC, 34'h07F56EA6,
    34'h03FEAB76, 34'h01FFD55B, 34'h00FFFAAA, 34'h007FFF55,
    34'h003FFFEA, 34'h001FFFFD, 34'h000FFFFF, 34'h0007FFFF,
    34'h0003FFFF, 34'h0001FFFF, 34'h0000FFFF, 34'h00007FFF,
    34'h00003FFF, 34'h00001FFF, 34'h00000FFF, 34'h000007FF,
    34'h000003FF, 34'h000001FF, 34'h000000FF, 34'h0000007F
  };

endpackage

>>> src/q2e_terms.sv
// Product and term stages: quaternion products, the sine and cosine terms,
// the gimbal test and the radicand for the pitch cosine. Uses q2e_pkg.
module q2e_terms import q2e_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  ctl_t                   in_ctl,
  input  logic signed [IN_W-1:0] qw,
  input  logic signed [IN_W-1:0] qx,
  input  logic signed [IN_W-1:0] qy,
  input  logic signed [IN_W-1:0] qz,
  output ctl_t                   out_ctl,
  output terms_t                 out_terms,
  output logic [SQ_W-1:0]        out_rad
);

  localparam vec_t ONE_V = vec_t'(ONE_TERM);
  localparam vec_t Q30_V = vec_t'(ONE_Q30);

  ctl_t c1, c2, c3;
  logic signed [2*IN_W-1:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;
  vec_t t_sr, t_cr, t_sy, t_cy, t_sp;
  terms_t t3;
  logic [ROOT_W-1:0] fa, fb;
  vec_t s30_w;
  logic lk;

  always_comb begin
    s30_w = t_sp <<< S30_SH;
    lk    = (t_sp >= ONE_V) || (t_sp <= -ONE_V);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
      out_ctl <= '0;
    end else if (en) begin
      c1 <= in_ctl;
      c2 <= c1;
      c3 <= '{valid: c2.valid, lock: lk, neg: t_sp[VEC_W-1]};
      out_ctl <= c3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= qw * qx;
      p_yz <= qy * qz;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_wz <= qw * qz;
      p_xy <= qx * qy;
      p_zz <= qz * qz;
      p_wy <= qw * qy;
      p_zx <= qz * qx;

      t_sr <= (vec_t'(p_wx) + vec_t'(p_yz)) <<< 1;
      t_cr <= ONE_V - ((vec_t'(p_xx) + vec_t'(p_yy)) <<< 1);
      t_sy <= (vec_t'(p_wz) + vec_t'(p_xy)) <<< 1;
      t_cy <= ONE_V - ((vec_t'(p_yy) + vec_t'(p_zz)) <<< 1);
      t_sp <= (vec_t'(p_wy) - vec_t'(p_zx)) <<< 1;

      t3  <= '{sr: t_sr, cr: t_cr, sy: t_sy, cy: t_cy, s30: s30_w};
      fa  <= ROOT_W'(Q30_V - s30_w);
      fb  <= ROOT_W'(Q30_V + s30_w);

      out_terms <= t3;
      out_rad   <= fa * fb;
    end
  end

endmodule

>>> src/q2e_sqrt.sv
// Pipelined integer square root, one result bit per stage, with the
// term bundle carried alongside. Uses q2e_pkg.
module q2e_sqrt import q2e_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  ctl_t              in_ctl,
  input  terms_t            in_terms,
  input  logic [SQ_W-1:0]   in_rad,
  output ctl_t              out_ctl,
  output terms_t            out_terms,
  output logic [ROOT_W-1:0] out_root
);

  ctl_t              c_q   [ROOT_W];
  terms_t            t_q   [ROOT_W];
  logic [SQ_W-1:0]   v_q   [ROOT_W];
  logic [ROOT_W-1:0] r_q   [ROOT_W];
  logic [ROOT_W+1:0] rem_q [ROOT_W];

  ctl_t              c_s   [ROOT_W];
  terms_t            t_s   [ROOT_W];
  logic [SQ_W-1:0]   v_s   [ROOT_W];
  logic [ROOT_W-1:0] r_s   [ROOT_W];
  logic [ROOT_W+1:0] rem_s [ROOT_W];
  logic [ROOT_W+3:0] sh    [ROOT_W];
  logic [ROOT_W+3:0] trial [ROOT_W];
  logic [ROOT_W+3:0] diff  [ROOT_W];
  logic              ge    [ROOT_W];

  always_comb begin
    c_s[0]   = in_ctl;
    t_s[0]   = in_terms;
    v_s[0]   = in_rad;
    r_s[0]   = '0;
    rem_s[0] = '0;
    for (int j = 1; j < ROOT_W; j++) begin
      c_s[j]   = c_q[j-1];
      t_s[j]   = t_q[j-1];
      v_s[j]   = v_q[j-1];
      r_s[j]   = r_q[j-1];
      rem_s[j] = rem_q[j-1];
    end
    // Stage j brings down the next bit pair, highest first.
    for (int j = 0; j < ROOT_W; j++) begin
      sh[j]    = {rem_s[j], v_s[j][2*(ROOT_W-1-j)+1 -: 2]};
      trial[j] = {2'b00, r_s[j], 2'b01};
      ge[j]    = sh[j] >= trial[j];
      diff[j]  = sh[j] - trial[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < ROOT_W; j++) c_q[j] <= '0;
    end else if (en) begin
      for (int j = 0; j < ROOT_W; j++) c_q[j] <= c_s[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < ROOT_W; j++) begin
        t_q[j]   <= t_s[j];
        v_q[j]   <= v_s[j];
        r_q[j]   <= {r_s[j][ROOT_W-2:0], ge[j]};
        rem_q[j] <= ge[j] ? diff[j][ROOT_W+1:0] : sh[j][ROOT_W+1:0];
      end
    end
  end

  assign out_ctl   = c_q[ROOT_W-1];
  assign out_terms = t_q[ROOT_W-1];
  assign out_root  = r_q[ROOT_W-1];

endmodule

>>> src/q2e_atan2.sv
// Vectoring CORDIC atan2: magnitude, leading-one search, normalizing shift,
// quadrant fold, then one micro-rotation per stage. Uses q2e_pkg.
module q2e_atan2 import q2e_pkg::*; #(
  parameter int STAGES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  ctl_t in_ctl,
  input  vec_t in_y,
  input  vec_t in_x,
  output ctl_t out_ctl,
  output cw_t  out_z
);

  localparam cw_t HALF_C = cw_t'(HALF_PI_Q30);

  ctl_t c1, c2, c3, c4;
  vec_t x1, y1, x2, y2;
  logic [VEC_W-1:0] m1, ax, ay;
  logic [POS_W-1:0] pos2, pos_n;
  logic zero2, zero3, zero4;
  cw_t x3, y3, x4, y4, z4;
  cw_t x3_n, y3_n;

  ctl_t c_q [STAGES];
  logic o_q [STAGES];
  cw_t  x_q [STAGES];
  cw_t  y_q [STAGES];
  cw_t  z_q [STAGES];
  ctl_t c_s [STAGES];
  logic o_s [STAGES];
  cw_t  x_s [STAGES];
  cw_t  y_s [STAGES];
  cw_t  z_s [STAGES];

  always_comb begin
    ax = in_x[VEC_W-1] ? VEC_W'(-in_x) : VEC_W'(in_x);
    ay = in_y[VEC_W-1] ? VEC_W'(-in_y) : VEC_W'(in_y);
    pos_n = '0;
    for (int b = 0; b < VEC_W; b++) begin
      if (m1[b]) pos_n = POS_W'(b);
    end
    if (pos2 > POS_W'(NORM_TOP)) begin
      x3_n = cw_t'(x2 >>> (pos2 - POS_W'(NORM_TOP)));
      y3_n = cw_t'(y2 >>> (pos2 - POS_W'(NORM_TOP)));
    end else begin
      x3_n = cw_t'(x2 <<< (POS_W'(NORM_TOP) - pos2));
      y3_n = cw_t'(y2 <<< (POS_W'(NORM_TOP) - pos2));
    end
    c_s[0] = c4;
    o_s[0] = zero4;
    x_s[0] = x4;
    y_s[0] = y4;
    z_s[0] = z4;
    for (int k = 1; k < STAGES; k++) begin
      c_s[k] = c_q[k-1];
      o_s[k] = o_q[k-1];
      x_s[k] = x_q[k-1];
      y_s[k] = y_q[k-1];
      z_s[k] = z_q[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
      c4 <= '0;
      for (int k = 0; k < STAGES; k++) c_q[k] <= '0;
    end else if (en) begin
      c1 <= in_ctl;
      c2 <= c1;
      c3 <= c2;
      c4 <= c3;
      for (int k = 0; k < STAGES; k++) c_q[k] <= c_s[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= in_x;
      y1 <= in_y;
      m1 <= (ax > ay) ? ax : ay;

      x2    <= x1;
      y2    <= y1;
      pos2  <= pos_n;
      zero2 <= (m1 == '0);

      x3    <= x3_n;
      y3    <= y3_n;
      zero3 <= zero2;

      // Fold the left half-plane onto the right one.
      zero4 <= zero3;
      if (x3[CW-1]) begin
        if (!y3[CW-1]) begin
          x4 <= y3;
          y4 <= -x3;
          z4 <= HALF_C;
        end else begin
          x4 <= -y3;
          y4 <= x3;
          z4 <= -HALF_C;
        end
      end else begin
        x4 <= x3;
        y4 <= y3;
        z4 <= '0;
      end

      for (int k = 0; k < STAGES; k++) begin
        o_q[k] <= o_s[k];
        if (!y_s[k][CW-1]) begin
          x_q[k] <= x_s[k] + (y_s[k] >>> k);
          y_q[k] <= y_s[k] - (x_s[k] >>> k);
          z_q[k] <= z_s[k] + cw_t'(ATAN_TBL[k]);
        end else begin
          x_q[k] <= x_s[k] - (y_s[k] >>> k);
          y_q[k] <= y_s[k] + (x_s[k] >>> k);
          z_q[k] <= z_s[k] - cw_t'(ATAN_TBL[k]);
        end
      end
    end
  end

  assign out_ctl = c_q[STAGES-1];
  assign out_z   = o_q[STAGES-1] ? '0 : z_q[STAGES-1];

endmodule

>>> src/quaternion_to_euler_zyx.sv
// Quaternion to ZYX Euler angles: four product and term stages, 31 square-root
// stages, four normalizing stages plus one stage per CORDIC rotation, and the
// output register. Throughput is one request per cycle; the whole pipe advances
// unless a result is held at the output. Reset (synchronous) clears only the
// control bits (valid, lock, neg), never the data registers.
`include "quaternion_to_euler_zyx_macros.svh"
module quaternion_to_euler_zyx import q2e_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [IN_W-1:0] quat_w,
  input  logic signed [IN_W-1:0] quat_x,
  input  logic signed [IN_W-1:0] quat_y,
  input  logic signed [IN_W-1:0] quat_z,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [15:0]     yaw_angle,
  output logic signed [14:0]     pitch_angle,
  output logic signed [15:0]     roll_angle,
  output logic                   gimbal_lock
);

  // Limits after rounding to the output fraction width.
  localparam cw_t PI_C   = cw_t'(PI_LIM);
  localparam cw_t HALF_C = cw_t'(HALF_LIM);
  localparam cw_t RND_C  = cw_t'(RND_HALF);
  localparam logic signed [15:0] ROLL_HI  = 16'(PI_LIM);
  localparam logic signed [14:0] PITCH_HI = 15'(HALF_LIM);

  // The whole pipe moves together; it only stops when a finished result
  // sits in the output register and the consumer is stalling.
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  ctl_t in_ctl;
  assign in_ctl = '{valid: in_valid, lock: 1'b0, neg: 1'b0};

  ctl_t   t_ctl, s_ctl, p_ctl;
  terms_t t_terms, s_terms;
  logic [SQ_W-1:0]   t_rad;
  logic [ROOT_W-1:0] s_root;
  cw_t z_roll, z_yaw, z_pitch;

  // Products, terms, gimbal test and the radicand (1 - s)(1 + s) in Q60.
  q2e_terms u_terms (
    .clk, .rst, .en,
    .in_ctl   (in_ctl),
    .qw       (quat_w),
    .qx       (quat_x),
    .qy       (quat_y),
    .qz       (quat_z),
    .out_ctl  (t_ctl),
    .out_terms(t_terms),
    .out_rad  (t_rad)
  );

  // The pitch cosine, floor(sqrt(radicand)); roll and yaw terms ride along.
  q2e_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_ctl   (t_ctl),
    .in_terms (t_terms),
    .in_rad   (t_rad),
    .out_ctl  (s_ctl),
    .out_terms(s_terms),
    .out_root (s_root)
  );

  // Three CORDIC lanes in lockstep. The pitch lane carries the control
  // bits; the others share its timing exactly.
  q2e_atan2 #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk, .rst, .en,
    .in_ctl (s_ctl),
    .in_y   (s_terms.sr),
    .in_x   (s_terms.cr),
    .out_ctl(),
    .out_z  (z_roll)
  );

  q2e_atan2 #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk, .rst, .en,
    .in_ctl (s_ctl),
    .in_y   (s_terms.sy),
    .in_x   (s_terms.cy),
    .out_ctl(),
    .out_z  (z_yaw)
  );

  q2e_atan2 #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk, .rst, .en,
    .in_ctl (s_ctl),
    .in_y   (s_terms.s30),
    .in_x   (vec_t'(s_root)),
    .out_ctl(p_ctl),
    .out_z  (z_pitch)
  );

  // Round half up from Q30 to the output format, then clamp.
  cw_t r_roll, r_yaw, r_pitch;
  cw_t c_roll, c_yaw, c_pitch;

  always_comb begin
    r_roll  = (z_roll + RND_C) >>> RND_SH;
    r_yaw   = (z_yaw + RND_C) >>> RND_SH;
    r_pitch = (z_pitch + RND_C) >>> RND_SH;
    c_roll  = (r_roll > PI_C) ? PI_C : ((r_roll < -PI_C) ? -PI_C : r_roll);
    c_yaw   = (r_yaw > PI_C) ? PI_C : ((r_yaw < -PI_C) ? -PI_C : r_yaw);
    if (p_ctl.lock) begin
      // Saturated pitch takes the sign of the sine term.
      c_pitch = p_ctl.neg ? -HALF_C : HALF_C;
    end else begin
      c_pitch = (r_pitch > HALF_C) ? HALF_C :
                ((r_pitch < -HALF_C) ? -HALF_C : r_pitch);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= p_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_angle  <= 16'(c_roll);
      yaw_angle   <= 16'(c_yaw);
      pitch_angle <= 15'(c_pitch);
      gimbal_lock <= p_ctl.lock;
    end
  end

  // A raised lock flag must come with a fully saturated pitch.
  `Q2E_IMPLY(a_lock_pitch, out_valid && gimbal_lock, (pitch_angle == PITCH_HI) || (pitch_angle == -PITCH_HI), "gimbal lock without saturated pitch")
  // Roll and yaw stay inside the clamp range.
  `Q2E_IMPLY(a_roll_yaw_range, out_valid, (roll_angle <= ROLL_HI) && (roll_angle >= -ROLL_HI) && (yaw_angle <= ROLL_HI) && (yaw_angle >= -ROLL_HI), "roll or yaw out of range")
  // Pitch stays inside plus or minus pi/2.
  `Q2E_IMPLY(a_pitch_range, out_valid, (pitch_angle <= PITCH_HI) && (pitch_angle >= -PITCH_HI), "pitch out of range")

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the quaternion to ZYX Euler angle converter.
// Depends on q2e_pkg and the quaternion_to_euler_zyx top level; no other files.
`timescale 1ns / 100ps
module testbench import q2e_pkg::*;;

  localparam int STAGES      = 16;
  localparam int LATENCY     = 40 + STAGES;
  localparam int IDLE_LIMIT  = 4000;
  localparam int RANDOM_REQS = 1500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] yaw_angle;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] roll_angle;
  logic gimbal_lock;

  // One expected set of angles per accepted request.
  typedef struct {
    logic [15:0] yaw;
    logic [14:0] pitch;
    logic [15:0] roll;
    logic        lock;
  } euler_t;

  euler_t angles_due[$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  bit     sending_done = 1'b0;

  always #10 clk = ~clk;

  quaternion_to_euler_zyx #(.CORDIC_STAGES(STAGES)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .yaw_angle(yaw_angle), .pitch_angle(pitch_angle),
    .roll_angle(roll_angle), .gimbal_lock(gimbal_lock)
  );

  // Angle table, atan(2^-i) in Q30, truncated.
  localparam longint ARCTAN_Q30 [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
    64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  function automatic longint mag64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Vectoring CORDIC: atan2(y, x) as a Q30 angle. >>> on longint is a floor shift.
  function automatic longint vector_angle(longint y, longint x);
    longint ang, m, xs, ys, t;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    m = (mag64(x) > mag64(y)) ? mag64(x) : mag64(y);
    while (m >= (64'sd1 <<< 30)) begin
      x = x >>> 1;
      y = y >>> 1;
      m = m >>> 1;
    end
    while (m < (64'sd1 <<< 29)) begin
      x = x * 2;
      y = y * 2;
      m = m * 2;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        ang = HALF_PI_Q30;
      end else begin
        x = -y;
        y = t;
        ang = -HALF_PI_Q30;
      end
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys;
        y -= xs;
        ang += ARCTAN_Q30[i];
      end else begin
        x -= ys;
        y += xs;
        ang -= ARCTAN_Q30[i];
      end
    end
    return ang;
  endfunction

  function automatic longint to_output_angle(longint q30, longint lim);
    longint r;
    r = (q30 + (64'sd1 <<< (29 - ANG_FRAC))) >>> (30 - ANG_FRAC);
    if (r > lim) return lim;
    if (r < -lim) return -lim;
    return r;
  endfunction

  // Floor square root, bit by bit.
  function automatic longint floor_sqrt(longint v);
    longint root, bitv;
    root = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > v) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >>> 1) + bitv;
      end else begin
        root = root >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return root;
  endfunction

  function automatic euler_t predict_euler(longint w, longint x, longint y, longint z);
    euler_t e;
    longint one_t, pi_cap, half_cap, sr, cr, sy, cy, sp, s30, c30;
    one_t = 64'sd1 <<< (2 * IN_FRAC);
    pi_cap = to_output_angle(PI_Q30, 64'sd1 <<< 40);
    half_cap = to_output_angle(HALF_PI_Q30, 64'sd1 <<< 40);
    sr = 2 * (w * x + y * z);
    cr = one_t - 2 * (x * x + y * y);
    sy = 2 * (w * z + x * y);
    cy = one_t - 2 * (y * y + z * z);
    sp = 2 * (w * y - z * x);
    e.roll = 16'(to_output_angle(vector_angle(sr, cr), pi_cap));
    e.yaw  = 16'(to_output_angle(vector_angle(sy, cy), pi_cap));
    if (mag64(sp) >= one_t) begin
      e.lock = 1'b1;
      e.pitch = 15'((sp < 0) ? -half_cap : half_cap);
    end else begin
      e.lock = 1'b0;
      s30 = sp * (64'sd1 <<< (30 - 2 * IN_FRAC));
      c30 = floor_sqrt(((64'sd1 <<< 30) - s30) * ((64'sd1 <<< 30) + s30));
      e.pitch = 15'(to_output_angle(vector_angle(s30, c30), half_cap));
    end
    return e;
  endfunction

  // Sends one request after a random gap; returns once it has been accepted.
  task automatic send_quat(input logic [15:0] w, x, y, z);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    quat_w <= w;
    quat_x <= x;
    quat_y <= y;
    quat_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    angles_due.push_back(predict_euler($signed(w), $signed(x), $signed(y), $signed(z)));
    @(negedge clk);
  endtask

  // Random component, biased toward the range ends and zero, full 16 bits sometimes.
  function automatic logic [15:0] rand_component();
    case ($urandom_range(0, 9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'd0;
      3: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  task automatic test_directed_corners();
    send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);        // identity
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);            // zero quaternion, every sine term zero
    send_quat(-16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);        // roll of pi
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);        // yaw of pi
    send_quat(16'sd11585, 16'sd0, 16'sd11585, 16'sd0);    // pitch just under +pi/2, no gimbal lock
    send_quat(16'sd11585, 16'sd0, -16'sd11585, 16'sd0);   // pitch just above -pi/2
    send_quat(16'sd16384, 16'sd0, 16'sd16384, 16'sd0);    // non-unit, large sine term
    send_quat(16'sd16384, -16'sd16384, -16'sd16384, 16'sd16384);
    send_quat(-16'sd16384, 16'sd16384, 16'sd16384, -16'sd16384);
    send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);        // y only: cosine terms negative
    send_quat(16'sd11585, 16'sd11585, 16'sd0, 16'sd0);    // roll of +pi/2
    send_quat(16'sd11585, 16'sd0, 16'sd0, -16'sd11585);   // yaw of -pi/2
    send_quat(16'sd1, -16'sd1, 16'sd1, -16'sd1);
    send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
    send_quat(16'sd8192, -16'sd8192, 16'sd8192, 16'sd8192);
    send_quat(16'sd11584, 16'sd0, 16'sd11584, 16'sd0);    // just below lock
  endtask

  // Mostly near-unit quaternions built from random directions; the rest is raw noise.
  task automatic test_random_orientations();
    int a, b, c, d;
    longint n;
    for (int k = 0; k < RANDOM_REQS; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_quat(rand_component(), rand_component(), rand_component(), rand_component());
      end else begin
        a = $urandom_range(0, 2000) - 1000;
        b = $urandom_range(0, 2000) - 1000;
        c = $urandom_range(0, 2000) - 1000;
        d = $urandom_range(0, 2000) - 1000;
        n = floor_sqrt(longint'(a) * a + longint'(b) * b + longint'(c) * c
                       + longint'(d) * d);
        if (n == 0) n = 1;
        send_quat(16'(a * 16384 / n), 16'(b * 16384 / n), 16'(c * 16384 / n),
                  16'(d * 16384 / n));
      end
    end
  endtask

  // Receiver stall: a fresh random hold per result, with long stretches of none.
  initial begin
    int hold;
    @(negedge clk);
    while (1) begin
      hold = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    euler_t want;
    if (!rst && out_valid && !out_stall) begin
      if (angles_due.size() == 0) begin
        $error("result with no request pending");
        mismatches++;
      end else begin
        want = angles_due.pop_front();
        if (yaw_angle !== want.yaw) begin
          $error("yaw_angle expected %0d got %0d", $signed(want.yaw), yaw_angle);
          mismatches++;
        end
        if (pitch_angle !== want.pitch) begin
          $error("pitch_angle expected %0d got %0d", $signed(want.pitch), pitch_angle);
          mismatches++;
        end
        if (roll_angle !== want.roll) begin
          $error("roll_angle expected %0d got %0d", $signed(want.roll), roll_angle);
          mismatches++;
        end
        if (gimbal_lock !== want.lock) begin
          $error("gimbal_lock expected %0b got %0b", want.lock, gimbal_lock);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (!sending_done || angles_due.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** quaternion_to_euler_zyx: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_directed_corners();
    test_random_orientations();
    in_valid <= 1'b0;
    sending_done = 1'b1;
    wait (angles_due.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("** quaternion_to_euler_zyx: PASSED **");
    end else begin
      $display("** quaternion_to_euler_zyx: FAILED **");
    end
    $finish;
  end

endmodule

>>> quaternion_to_euler_zyx.f
+incdir+src
src/q2e_pkg.sv
src/q2e_terms.sv
src/q2e_sqrt.sv
src/q2e_atan2.sv
src/quaternion_to_euler_zyx.sv
tb/testbench.sv
